### sv/ptaom_pkg.sv
`timescale 1ns / 1ps
// Shared constants, field layout and types for the page translation block.
package ptaom_pkg;

   localparam int unsigned PAGE_BYTES_DEF    = 8192;
   localparam int unsigned TABLE_ENTRIES_DEF = 64;
   localparam int unsigned ADDR_BITS_DEF     = 48;

   localparam int unsigned VA_W    = 48;
   localparam int unsigned SID_W   = 8;
   localparam int unsigned SIZE_W  = 14;
   localparam int unsigned PA_W    = 48;
   localparam int unsigned FAULT_W = 2;

   localparam int unsigned WORD_BYTES = 8;
   localparam int unsigned WORD_LSB   = $clog2(WORD_BYTES);

   localparam int unsigned REQ_SID_LSB  = VA_W;
   localparam int unsigned REQ_SIZE_LSB = VA_W + SID_W;
   localparam int unsigned REQ_TDATA_W  = ((VA_W + SID_W + SIZE_W + 7) / 8) * 8;

   localparam int unsigned RSP_FAULT_LSB = PA_W;
   localparam int unsigned RSP_ALLOC_BIT = PA_W + FAULT_W;
   localparam int unsigned RSP_TDATA_W   = ((PA_W + FAULT_W + 1 + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W     = RSP_TDATA_W - (PA_W + FAULT_W + 1);

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_ALIGN  = 2'd1,
      FAULT_MCHECK = 2'd2,
      FAULT_FULL   = 2'd3
   } fault_type;

   typedef struct packed {
      logic hit;
      logic full;
      logic alloc;
   } lookup_flags_type;

endpackage

### sv/ptaom_lookup.sv
`timescale 1ns / 1ps
// Fully associative page table with bump allocation of frames on a miss.
module ptaom_lookup
   import ptaom_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int unsigned ADDR_BITS     = ADDR_BITS_DEF,
   parameter int unsigned PAGE_BYTES    = PAGE_BYTES_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          lookup_fire,
   input  logic [ADDR_BITS-$clog2(PAGE_BYTES)+SID_W-1:0] key,
   input  logic                                          csr_load,
   input  logic [ADDR_BITS-$clog2(PAGE_BYTES)-1:0]       csr_pn,
   output logic [ADDR_BITS-$clog2(PAGE_BYTES)-1:0]       frame_pn,
   output lookup_flags_type                              flags
);

   localparam int unsigned OFF_BITS = $clog2(PAGE_BYTES);
   localparam int unsigned PN_W     = ADDR_BITS - OFF_BITS;
   localparam int unsigned KEY_W    = PN_W + SID_W;
   localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);

   logic [KEY_W-1:0]         key_ff [TABLE_ENTRIES];
   logic [PN_W-1:0]          frame_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [PN_W-1:0]          next_pn_ff, next_pn_in;
   logic [PN_W-1:0]          rd_frame_ff;
   logic [PN_W-1:0]          alloc_pn_ff;
   lookup_flags_type         flags_ff, flags_in;

   logic [TABLE_ENTRIES-1:0] match;
   logic [TABLE_ENTRIES-1:0] free_vec;
   logic [TABLE_ENTRIES-1:0] hit_first;
   logic [TABLE_ENTRIES-1:0] free_first;
   logic [IDX_W-1:0]         hit_idx;
   logic [IDX_W-1:0]         free_idx;
   logic                     hit;
   logic                     have_free;
   logic                     alloc;

   function automatic logic [IDX_W-1:0] encode(input logic [TABLE_ENTRIES-1:0] onehot);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (onehot[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == key);
      end
   end

   assign free_vec   = ~valid_ff;
   assign hit_first  = match & (~match + TABLE_ENTRIES'(1));
   assign free_first = free_vec & (~free_vec + TABLE_ENTRIES'(1));
   assign hit_idx    = encode(hit_first);
   assign free_idx   = encode(free_first);
   assign hit        = |match;
   assign have_free  = |free_vec;
   assign alloc      = lookup_fire && !hit && have_free;

   always_comb begin
      valid_in = valid_ff;
      if (alloc) begin
         valid_in[free_idx] = 1'b1;
      end
   end

   always_comb begin
      next_pn_in = next_pn_ff;
      if (csr_load) begin
         next_pn_in = csr_pn;
      end else if (alloc) begin
         next_pn_in = next_pn_ff + PN_W'(1);
      end
   end

   always_comb begin
      flags_in.hit   = hit;
      flags_in.full  = !hit && !have_free;
      flags_in.alloc = !hit && have_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         next_pn_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         next_pn_ff <= next_pn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         key_ff[free_idx]    <= key;
         frame_mem[free_idx] <= next_pn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_fire) begin
         rd_frame_ff <= frame_mem[hit_idx];
         alloc_pn_ff <= next_pn_ff;
         flags_ff    <= flags_in;
      end
   end

   assign frame_pn = flags_ff.hit ? rd_frame_ff : alloc_pn_ff;
   assign flags    = flags_ff;

endmodule

### sv/ptaom_check.sv
`timescale 1ns / 1ps
// Physical address assembly, size and alignment check, and result register.
module ptaom_check
   import ptaom_pkg::*;
#(
   parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
   parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic                                    clock,
   input  logic                                    result_load,
   input  logic [ADDR_BITS-$clog2(PAGE_BYTES)-1:0] frame_pn,
   input  logic [$clog2(PAGE_BYTES)-1:0]           offset,
   input  logic [SIZE_W-1:0]                       size,
   input  lookup_flags_type                        flags,
   output logic [PA_W-1:0]                         phys_addr,
   output fault_type                               fault_code,
   output logic                                    newly_allocated
);

   localparam int unsigned OFF_BITS = $clog2(PAGE_BYTES);
   localparam int unsigned SUM_W    = ((OFF_BITS > SIZE_W) ? OFF_BITS : SIZE_W) + 1;

   logic [PA_W-1:0]      phys_ff, phys_in;
   fault_type            fault_ff, fault_in;
   logic                 alloc_ff, alloc_in;

   logic [ADDR_BITS-1:0] pa;
   logic [WORD_LSB-1:0]  small_size;
   logic [WORD_LSB-1:0]  low_off;
   logic [SUM_W-1:0]     end_off;
   logic                 is_small;
   logic                 small_pow2;

   assign pa         = {frame_pn, offset};
   assign small_size = size[WORD_LSB-1:0];
   assign low_off    = offset[WORD_LSB-1:0];
   assign end_off    = SUM_W'(offset) + SUM_W'(size);
   assign is_small   = size < SIZE_W'(WORD_BYTES);
   assign small_pow2 = (small_size != '0) &&
                       ((small_size & (small_size - WORD_LSB'(1))) == '0);

   always_comb begin
      phys_in  = PA_W'(pa);
      fault_in = FAULT_NONE;
      alloc_in = flags.alloc;
      if (flags.full) begin
         phys_in  = '0;
         fault_in = FAULT_FULL;
         alloc_in = 1'b0;
      end else if (is_small) begin
         if (!small_pow2) begin
            fault_in = FAULT_MCHECK;
         end else if (((small_size - WORD_LSB'(1)) & low_off) != '0) begin
            fault_in = FAULT_ALIGN;
         end
      end else begin
         if (end_off > SUM_W'(PAGE_BYTES)) begin
            fault_in = FAULT_MCHECK;
         end else if (low_off != '0) begin
            fault_in = FAULT_ALIGN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         phys_ff  <= phys_in;
         fault_ff <= fault_in;
         alloc_ff <= alloc_in;
      end
   end

   assign phys_addr       = phys_ff;
   assign fault_code      = fault_ff;
   assign newly_allocated = alloc_ff;

endmodule

### sv/page_translate_allocate_on_miss.sv
`timescale 1ns / 1ps
// Page translation with allocation on demand: one request per cycle while the
// result side is not stalled, through three register stages (request, table
// lookup, result); a request's result is held in the result stage and shown on
// rsp_tvalid until the result side takes it. The lookup compares the key
// against every valid entry of the fully associative table and allocates the
// next free frame on a miss in the same cycle, so back-to-back requests to the
// same new page see the allocation.
// A write on the csr port reloads the frame allocator from its page-aligned
// base; write it only while no request is in flight.
module page_translate_allocate_on_miss
   import ptaom_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int unsigned ADDR_BITS     = ADDR_BITS_DEF,
   parameter int unsigned PAGE_BYTES    = PAGE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // virt_addr, space_id, access_bytes
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // phys_addr, fault_code, newly_allocated
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [PA_W-1:0]        csr_data    // free_page_base
);

   localparam int unsigned OFF_BITS = $clog2(PAGE_BYTES);
   localparam int unsigned PN_W     = ADDR_BITS - OFF_BITS;
   localparam int unsigned KEY_W    = PN_W + SID_W;

   logic                 s0_valid_ff, s0_valid_in;
   logic [VA_W-1:0]      va_ff;
   logic [SID_W-1:0]     sid_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic [OFF_BITS-1:0]  off_s1_ff;
   logic [SIZE_W-1:0]    size_s1_ff;
   logic                 out_valid_ff, out_valid_in;

   logic                 req_xfer;
   logic                 out_rdy;
   logic                 s1_rdy;
   logic                 s0_fire;
   logic                 s1_fire;
   logic [ADDR_BITS-1:0] va_addr;
   logic [KEY_W-1:0]     key;
   logic [ADDR_BITS-1:0] base_addr;
   logic [PN_W-1:0]      csr_pn;
   logic                 csr_load;
   logic [PN_W-1:0]      frame_pn;
   lookup_flags_type     flags;
   logic [PA_W-1:0]      phys_addr;
   fault_type            fault_code;
   logic                 newly_allocated;

   assign out_rdy    = !out_valid_ff || rsp_tready;
   assign s1_rdy     = !s1_valid_ff || out_rdy;
   assign s1_fire    = s1_valid_ff && out_rdy;
   assign s0_fire    = s0_valid_ff && s1_rdy;
   assign req_tready = !s0_valid_ff || s1_rdy;
   assign req_xfer   = req_tvalid && req_tready;

   assign csr_ready = 1'b1;
   assign csr_load  = csr_valid && csr_ready;
   assign base_addr = ADDR_BITS'(csr_data);
   assign csr_pn    = base_addr[ADDR_BITS-1:OFF_BITS];

   assign va_addr = ADDR_BITS'(va_ff);
   assign key     = {va_addr[ADDR_BITS-1:OFF_BITS], sid_ff};

   always_comb begin
      s0_valid_in  = req_xfer ? 1'b1 : (s0_fire ? 1'b0 : s0_valid_ff);
      s1_valid_in  = s0_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_fire ? 1'b1 : ((out_valid_ff && rsp_tready) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         va_ff   <= req_tdata[VA_W-1:0];
         sid_ff  <= req_tdata[REQ_SID_LSB +: SID_W];
         size_ff <= req_tdata[REQ_SIZE_LSB +: SIZE_W];
      end
      if (s0_fire) begin
         off_s1_ff  <= va_addr[OFF_BITS-1:0];
         size_s1_ff <= size_ff;
      end
   end

   ptaom_lookup #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_lookup (
      .clock      (clock),
      .reset      (reset),
      .lookup_fire(s0_fire),
      .key        (key),
      .csr_load   (csr_load),
      .csr_pn     (csr_pn),
      .frame_pn   (frame_pn),
      .flags      (flags)
   );

   ptaom_check #(
      .ADDR_BITS (ADDR_BITS),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_check (
      .clock          (clock),
      .result_load    (s1_fire),
      .frame_pn       (frame_pn),
      .offset         (off_s1_ff),
      .size           (size_s1_ff),
      .flags          (flags),
      .phys_addr      (phys_addr),
      .fault_code     (fault_code),
      .newly_allocated(newly_allocated)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, newly_allocated, fault_code, phys_addr};

endmodule

### sv/ptaom_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the page translation block, bound to the top level.
module ptaom_checker
   import ptaom_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_FAULT_LSB +: FAULT_W] == FAULT_FULL) |->
      (rsp_tdata[PA_W-1:0] == '0) && !rsp_tdata[RSP_ALLOC_BIT])
      else $error("table-full result with address or allocation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:RSP_ALLOC_BIT+1] == '0)
      else $error("result padding not zero");

endmodule

bind page_translate_allocate_on_miss ptaom_checker u_ptaom_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
